// File: design/stq_pkg.sv
// Shared types and codes for the software timer queue.
package stq_pkg;

    // Operation codes
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // Back-end state machine
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CMD,
        BK_SCAN,
        BK_FIRE,
        BK_DONE
    } bk_state_t;

endpackage

// File: design/stq_cmd_fifo.sv
// Short command queue between the front end and the back end.
module stq_cmd_fifo import stq_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg;
    logic             wptr_next;
    logic             rptr_reg;
    logic             rptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rptr_reg];

    // Pointer and count update
    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// File: design/stq_engine.sv
// Back end: slot table, command execution and expiry scan.
module stq_engine import stq_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic [1:0]           cmd_op,
    input  logic [TIME_BITS-1:0] cmd_now,
    input  logic [31:0]          cmd_delay,
    input  logic [31:0]          cmd_period,
    input  logic [3:0]           cmd_id,
    output logic                 cmd_pop,
    output logic                 res_strobe,
    output logic [1:0]           status,
    output logic [3:0]           timer_id_res,
    output logic                 fired,
    output logic                 last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    bk_state_t state_reg;
    bk_state_t state_next;

    logic [SLOTS-1:0]     used_reg;
    logic [SLOTS-1:0]     canc_reg;
    logic [SLOTS-1:0]     seen_reg;
    logic [TIME_BITS-1:0] exp_reg [SLOTS];
    logic [31:0]          per_reg [SLOTS];

    logic [1:0]           op_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [31:0]          delay_reg;
    logic [31:0]          period_reg;
    logic [3:0]           id_reg;

    // scan walk
    logic [IW-1:0]        idx_reg;
    logic                 best_ok_reg;
    logic [IW-1:0]        best_reg;
    logic [TIME_BITS-1:0] best_exp_reg;

    // pending output (held to set last)
    logic                 pend_reg;
    logic [3:0]           pend_id_reg;

    logic                 free_ok;
    logic [IW-1:0]        free_idx;
    logic                 cand;
    logic                 scan_end;
    logic [AW-1:0]        sum_w;
    logic [TIME_BITS-1:0] add_b;
    logic [31:0]          add_inc;
    logic [TIME_BITS-1:0] add_res;
    logic                 id_in_range;

    // lowest free slot
    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // saturating adder shared by create and re-arm
    always_comb
    begin
        add_b   = now_reg;
        add_inc = (op_reg == OP_CREATE) ? delay_reg : per_reg[best_reg];
        sum_w   = AW'(add_b) + AW'(add_inc);
        add_res = (sum_w > AW'(TMAX)) ? TMAX : sum_w[TIME_BITS-1:0];
    end

    assign id_in_range = ({28'd0, id_reg} < 32'(SLOTS));
    assign cand = used_reg[idx_reg] && !seen_reg[idx_reg] && (exp_reg[idx_reg] <= now_reg)
                  && (!best_ok_reg || (exp_reg[idx_reg] < best_exp_reg));
    assign scan_end = (idx_reg == IW'(SLOTS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (cmd_valid) state_next = BK_CMD;
            BK_CMD:  state_next = (op_reg == OP_TICK) ? BK_SCAN : BK_IDLE;
            BK_SCAN: if (scan_end) state_next = BK_FIRE;
            BK_FIRE: state_next = best_ok_reg ? BK_SCAN : BK_DONE;
            BK_DONE: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_pop      = (state_reg == BK_IDLE) && cmd_valid;
        res_strobe   = 1'b0;
        status       = ST_OK;
        timer_id_res = 4'd0;
        fired        = 1'b0;
        last         = 1'b0;
        unique case (state_reg)
            BK_CMD:
            begin
                if (op_reg == OP_CREATE)
                begin
                    res_strobe   = 1'b1;
                    last         = 1'b1;
                    status       = free_ok ? ST_OK : ST_FULL;
                    timer_id_res = free_ok ? 4'(free_idx) : 4'd0;
                end
                else if (op_reg == OP_CANCEL)
                begin
                    res_strobe   = 1'b1;
                    last         = 1'b1;
                    timer_id_res = id_reg;
                    status = (id_in_range && used_reg[IW'(id_reg)] && !canc_reg[IW'(id_reg)])
                             ? ST_OK : ST_REFUSED;
                end
            end
            BK_FIRE:
            begin
                // previous fire is emitted once the next live one is known
                if (pend_reg && best_ok_reg && !canc_reg[best_reg])
                begin
                    res_strobe   = 1'b1;
                    fired        = 1'b1;
                    timer_id_res = pend_id_reg;
                end
            end
            BK_DONE:
            begin
                if (pend_reg)
                begin
                    res_strobe   = 1'b1;
                    fired        = 1'b1;
                    last         = 1'b1;
                    timer_id_res = pend_id_reg;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            used_reg      <= '0;
            canc_reg      <= '0;
            seen_reg      <= '0;
            idx_reg       <= '0;
            best_ok_reg   <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                BK_CMD:
                begin
                    seen_reg    <= '0;
                    idx_reg     <= '0;
                    best_ok_reg <= 1'b0;
                    pend_reg    <= 1'b0;
                    if (op_reg == OP_CREATE && free_ok)
                    begin
                        used_reg[free_idx] <= 1'b1;
                        canc_reg[free_idx] <= 1'b0;
                    end
                    else if (op_reg == OP_CANCEL && id_in_range
                             && used_reg[IW'(id_reg)])
                    begin
                        canc_reg[IW'(id_reg)] <= 1'b1;
                    end
                    else if (op_reg == OP_CLEAR)
                    begin
                        used_reg <= '0;
                        canc_reg <= '0;
                    end
                end
                BK_SCAN:
                begin
                    if (cand)
                    begin
                        best_ok_reg <= 1'b1;
                    end
                    if (!scan_end)
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                BK_FIRE:
                begin
                    idx_reg     <= '0;
                    best_ok_reg <= 1'b0;
                    if (best_ok_reg)
                    begin
                        seen_reg[best_reg] <= 1'b1;
                        if (canc_reg[best_reg])
                        begin
                            used_reg[best_reg] <= 1'b0;
                            canc_reg[best_reg] <= 1'b0;
                        end
                        else
                        begin
                            pend_reg <= 1'b1;
                            if (per_reg[best_reg] == 32'd0)
                            begin
                                used_reg[best_reg] <= 1'b0;
                            end
                        end
                    end
                end
                BK_DONE: pend_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            op_reg     <= cmd_op;
            now_reg    <= cmd_now;
            delay_reg  <= cmd_delay;
            period_reg <= cmd_period;
            id_reg     <= cmd_id;
        end
        if (state_reg == BK_CMD && op_reg == OP_CREATE && free_ok)
        begin
            exp_reg[free_idx] <= add_res;
            per_reg[free_idx] <= period_reg;
        end
        if (state_reg == BK_SCAN && cand)
        begin
            best_reg     <= idx_reg;
            best_exp_reg <= exp_reg[idx_reg];
        end
        if (state_reg == BK_FIRE && best_ok_reg && !canc_reg[best_reg])
        begin
            pend_id_reg <= 4'(best_reg);
            if (per_reg[best_reg] != 32'd0)
            begin
                exp_reg[best_reg] <= add_res;
            end
        end
    end

endmodule

// File: design/software_timer_queue_unit.sv
// Top level of the software timer queue.
//
//  Channel  | Handshake            | Ports
//  command  | start & !busy        | op, now, delay, period, timer_id
//  result   | res_valid (strobe)   | status, timer_id_res, fired, last
//
// Create and cancel results come from the back end's command state, once the item has passed
// the queue and the payload registers; the back end spends an idle and a command state on each create, cancel or clear.
// A tick holds the back end for one scan of the table per expired slot, plus a closing scan and a done state:
// one slot of the table is compared per cycle in the search for the earliest.
// Reset empties the table at once; no clearing pass.
// Results cannot be stalled; busy rises while the two-entry queue is full.
module software_timer_queue_unit import stq_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           op,
    input  logic [TIME_BITS-1:0] now,
    input  logic [31:0]          delay,
    input  logic [31:0]          period,
    input  logic [3:0]           timer_id,
    output logic                 res_valid,
    output logic [1:0]           status,
    output logic [3:0]           timer_id_res,
    output logic                 fired,
    output logic                 last
);

    localparam int CW = 2 + TIME_BITS + 32 + 32 + 4;

    logic          full;
    logic          not_empty;
    logic          pop;
    logic [CW-1:0] pop_data;

    assign busy = full;

    stq_cmd_fifo #(.WIDTH(CW)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !full),
        .push_data ({op, now, delay, period, timer_id}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    stq_engine #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (not_empty),
        .cmd_op       (pop_data[CW-1 -: 2]),
        .cmd_now      (pop_data[CW-3 -: TIME_BITS]),
        .cmd_delay    (pop_data[67:36]),
        .cmd_period   (pop_data[35:4]),
        .cmd_id       (pop_data[3:0]),
        .cmd_pop      (pop),
        .res_strobe   (res_valid),
        .status       (status),
        .timer_id_res (timer_id_res),
        .fired        (fired),
        .last         (last)
    );

endmodule

// File: test/testbench.sv
// Testbench for the software timer queue: directed and random items checked against a slot-table predictor.
module testbench;
    import stq_pkg::*;

    localparam int NSLOTS = 16;
    localparam int TBITS  = 48;
    localparam logic [TBITS-1:0] TMAX = {TBITS{1'b1}};

    typedef struct {
        logic [1:0]       op;
        logic [TBITS-1:0] now;
        logic [31:0]      delay;
        logic [31:0]      period;
        logic [3:0]       id;
    } cmd_t;

    typedef struct {
        logic [1:0] status;
        logic [3:0] id;
        logic       fired;
        logic       last;
    } res_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [1:0]       op = OP_CLEAR;
    logic [TBITS-1:0] now = '0;
    logic [31:0]      delay = '0;
    logic [31:0]      period = '0;
    logic [3:0]       timer_id = '0;
    logic             busy;
    logic             res_valid;
    logic [1:0]       status;
    logic [3:0]       timer_id_res;
    logic             fired;
    logic             last;

    // Predicted slot table
    logic             slot_busy [NSLOTS];
    logic             slot_dead [NSLOTS];
    logic [TBITS-1:0] slot_due [NSLOTS];
    logic [31:0]      slot_reload [NSLOTS];

    cmd_t pending_cmds[$];
    res_t due_results[$];
    int   accepted = 0;
    int   total_cmds = 0;
    bit   failed = 0;
    int   gap = 0;
    bit   calm = 0;
    logic [TBITS-1:0] clock_now = 48'd1000;

    software_timer_queue_unit #(.SLOTS(NSLOTS), .TIME_BITS(TBITS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .now(now),
        .delay(delay), .period(period), .timer_id(timer_id), .res_valid(res_valid),
        .status(status), .timer_id_res(timer_id_res), .fired(fired), .last(last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [TBITS-1:0] add_sat(logic [TBITS-1:0] base, logic [31:0] inc);
        logic [TBITS:0] sum;
        sum = {1'b0, base} + {17'd0, inc};
        return sum[TBITS] ? TMAX : sum[TBITS-1:0];
    endfunction

    function automatic res_t mk_res(logic [1:0] st, logic [3:0] id, logic f, logic l);
        res_t r;
        r.status = st;
        r.id = id;
        r.fired = f;
        r.last = l;
        return r;
    endfunction

    // Update the slot table for one accepted item and queue its results
    task automatic apply_cmd(cmd_t c);
        bit found;
        bit seen [NSLOTS];
        int fire_ids [NSLOTS];
        int count;
        int best;
        found = 0;
        count = 0;
        case (c.op)
            OP_CREATE:
            begin
                for (int i = 0; i < NSLOTS; i++)
                begin
                    if (!found && !slot_busy[i])
                    begin
                        found = 1;
                        slot_busy[i] = 1;
                        slot_dead[i] = 0;
                        slot_due[i] = add_sat(c.now, c.delay);
                        slot_reload[i] = c.period;
                        due_results.push_back(mk_res(ST_OK, 4'(i), 1'b0, 1'b1));
                    end
                end
                if (!found)
                    due_results.push_back(mk_res(ST_FULL, 4'd0, 1'b0, 1'b1));
            end
            OP_CANCEL:
            begin
                if (slot_busy[c.id] && !slot_dead[c.id])
                begin
                    slot_dead[c.id] = 1;
                    due_results.push_back(mk_res(ST_OK, c.id, 1'b0, 1'b1));
                end
                else
                    due_results.push_back(mk_res(ST_REFUSED, c.id, 1'b0, 1'b1));
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NSLOTS; i++)
                begin
                    slot_busy[i] = 0;
                    slot_dead[i] = 0;
                end
            end
            default:
            begin
                for (int i = 0; i < NSLOTS; i++)
                    seen[i] = 0;
                // earliest expiry first, lowest slot on ties; each slot once
                do
                begin
                    best = -1;
                    for (int i = 0; i < NSLOTS; i++)
                        if (slot_busy[i] && !seen[i] && slot_due[i] <= c.now)
                            if (best < 0 || slot_due[i] < slot_due[best])
                                best = i;
                    if (best >= 0)
                    begin
                        seen[best] = 1;
                        if (slot_dead[best])
                        begin
                            slot_busy[best] = 0;
                            slot_dead[best] = 0;
                        end
                        else
                        begin
                            fire_ids[count] = best;
                            count++;
                            if (slot_reload[best] != 0)
                                slot_due[best] = add_sat(c.now, slot_reload[best]);
                            else
                                slot_busy[best] = 0;
                        end
                    end
                end while (best >= 0);
                for (int k = 0; k < count; k++)
                    due_results.push_back(mk_res(ST_OK, 4'(fire_ids[k]), 1'b1,
                                                 k == count - 1));
            end
        endcase
    endtask

    function automatic cmd_t mk_cmd(logic [1:0] o, logic [TBITS-1:0] t, logic [31:0] d,
                                    logic [31:0] p, logic [3:0] id);
        cmd_t c;
        c.op = o;
        c.now = t;
        c.delay = d;
        c.period = p;
        c.id = id;
        return c;
    endfunction

    // Driver: present queued items, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin : driver
        cmd_t c;
        bit   drive;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            drive = 0;
            if (start && !busy)
            begin
                apply_cmd(mk_cmd(op, now, delay, period, timer_id));
                accepted++;
                if ($urandom_range(0, 15) == 0)
                    calm = !calm;
                if (calm)
                    gap = 0;
                else if ($urandom_range(0, 9) == 0)
                    gap = $urandom_range(20, 80);
                else
                    gap = $urandom_range(0, 3);
            end
            if (start && busy)
                drive = 1;
            else if (gap > 0)
                gap--;
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds.pop_front();
                op <= c.op;
                now <= c.now;
                delay <= c.delay;
                period <= c.period;
                timer_id <= c.id;
                drive = 1;
            end
            start <= drive;
        end
    end

    // Monitor: every strobed result against the oldest expectation
    always @(posedge clk)
    begin : monitor
        res_t e;
        if (rst_n && res_valid)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: status %0d id %0d fired %0d last %0d",
                       status, timer_id_res, fired, last);
                failed = 1;
            end
            else
            begin
                e = due_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    failed = 1;
                end
                if (timer_id_res !== e.id)
                begin
                    $error("timer_id_res: expected %0d, got %0d", e.id, timer_id_res);
                    failed = 1;
                end
                if (fired !== e.fired)
                begin
                    $error("fired: expected %0d, got %0d", e.fired, fired);
                    failed = 1;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, last);
                    failed = 1;
                end
            end
        end
    end

    // Random item, time mostly moving forward
    function automatic cmd_t rand_cmd();
        int sel;
        logic [31:0] d;
        logic [31:0] p;
        logic [TBITS-1:0] t;
        sel = $urandom_range(0, 99);
        clock_now = clock_now + TBITS'($urandom_range(0, 40));
        t = clock_now;
        if ($urandom_range(0, 19) == 0)
            t = TBITS'({$urandom, $urandom});
        else if ($urandom_range(0, 29) == 0)
            t = TMAX - TBITS'($urandom_range(0, 100));
        d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
        case ($urandom_range(0, 3))
            0: p = $urandom;
            1: p = $urandom_range(1, 50);
            default: p = 32'd0;
        endcase
        if (sel < 38)
            return mk_cmd(OP_CREATE, t, d, p, 4'($urandom));
        else if (sel < 60)
            return mk_cmd(OP_CANCEL, t, $urandom, $urandom, 4'($urandom));
        else if (sel < 96)
            return mk_cmd(OP_TICK, t, $urandom, $urandom, 4'($urandom));
        else
            return mk_cmd(OP_CLEAR, t, $urandom, $urandom, 4'($urandom));
    endfunction

    // Stimulus and end of run
    initial
    begin
        for (int i = 0; i < NSLOTS; i++)
        begin
            slot_busy[i] = 0;
            slot_dead[i] = 0;
            slot_due[i] = '0;
            slot_reload[i] = '0;
        end
        // directed: fill past full, cancel cases, ties, saturation, clear
        pending_cmds.push_back(mk_cmd(OP_TICK, 48'd0, 32'd0, 32'd0, 4'd0));
        pending_cmds.push_back(mk_cmd(OP_CREATE, 48'd100, 32'd0, 32'd0, 4'd0));
        pending_cmds.push_back(mk_cmd(OP_CREATE, 48'd100, 32'd5, 32'd7, 4'd0));
        pending_cmds.push_back(mk_cmd(OP_CREATE, 48'd100, 32'd5, 32'd0, 4'd0));
        pending_cmds.push_back(mk_cmd(OP_CREATE, TMAX - 48'd3, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 4'd0));
        for (int i = 0; i < 13; i++)
            pending_cmds.push_back(mk_cmd(OP_CREATE, 48'd100, 32'(i + 1), 32'(i % 3), 4'd0));
        pending_cmds.push_back(mk_cmd(OP_CANCEL, 48'd101, 32'd0, 32'd0, 4'd2));
        pending_cmds.push_back(mk_cmd(OP_CANCEL, 48'd101, 32'd0, 32'd0, 4'd2));
        pending_cmds.push_back(mk_cmd(OP_CANCEL, 48'd101, 32'd0, 32'd0, 4'd15));
        pending_cmds.push_back(mk_cmd(OP_TICK, 48'd110, 32'd0, 32'd0, 4'd0));
        pending_cmds.push_back(mk_cmd(OP_TICK, TMAX, 32'd0, 32'd0, 4'd0));
        pending_cmds.push_back(mk_cmd(OP_CLEAR, TMAX, 32'd0, 32'd0, 4'd0));
        pending_cmds.push_back(mk_cmd(OP_CANCEL, 48'd0, 32'd0, 32'd0, 4'd0));
        pending_cmds.push_back(mk_cmd(OP_TICK, TMAX, 32'd0, 32'd0, 4'd0));
        for (int i = 0; i < 100; i++)
            pending_cmds.push_back(rand_cmd());
        total_cmds = pending_cmds.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted == total_cmds);
        wait (due_results.size() == 0);
        repeat (400) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $error("%0d results never arrived", due_results.size());
            failed = 1;
        end
        if (!failed)
            $display("PASS software_timer_queue_unit");
        else
            $display("FAIL software_timer_queue_unit");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(12 * 1000000);
        $display("FAIL software_timer_queue_unit");
        $finish;
    end

endmodule
